>>> rtl/core/ppee_pkg.sv
// ----------------------------------------------------------------------------
// ppee_pkg
// Shared types and constants of the two-page ping-pong eeprom emulator.
// ----------------------------------------------------------------------------
package ppee_pkg;

    localparam int PAGE_BYTES_DEF = 2048;
    localparam int HEADER_BYTES   = 4;
    localparam int PS_W           = 12;
    localparam int ADDR_W         = 11;
    localparam int BYTE_W         = 8;
    localparam int IN_TDATA_W     = 24;
    localparam int OUT_TDATA_W    = 16;

    // input mode codes
    typedef enum logic [1:0] {
        MODE_READ  = 2'd0,
        MODE_WRITE = 2'd1,
        MODE_ERASE = 2'd2,
        MODE_NONE  = 2'd3
    } t_mode;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_ABORT = 2'd2
    } t_status;

    // classified command kinds
    typedef enum logic [1:0] {
        K_BAD   = 2'd0,
        K_READ  = 2'd1,
        K_WRITE = 2'd2,
        K_ERASE = 2'd3
    } t_kind;

    // command handed from front to back
    typedef struct packed {
        t_kind                 kind;
        logic [ADDR_W-1:0]     addr;
        logic [BYTE_W-1:0]     data;
        logic                  last;
        logic                  in_range;
        logic [PS_W-1:0]       size;
    } t_cmd;

    // back-end sequencer states
    typedef enum logic [1:0] {
        BS_IDLE = 2'd0,
        BS_READ = 2'd1,
        BS_COPY = 2'd2,
        BS_EXEC = 2'd3
    } t_bstate;

endpackage

>>> rtl/core/ppee_ram.sv
// ----------------------------------------------------------------------------
// ppee_ram
// Generic single-port ram with registered read.
// ----------------------------------------------------------------------------
module ppee_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2044
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/ppee_front.sv
// ----------------------------------------------------------------------------
// ppee_front
// Accepts input beats, checks config and range, registers a command.
// ----------------------------------------------------------------------------
module ppee_front #(
    parameter int PAGE_BYTES = ppee_pkg::PAGE_BYTES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [1:0]                   i_mode,
    input  logic [ppee_pkg::ADDR_W-1:0]  i_addr,
    input  logic [ppee_pkg::BYTE_W-1:0]  i_data,
    input  logic                         i_last,
    input  logic [ppee_pkg::PS_W-1:0]    i_page_size,
    output logic                         o_valid,
    output ppee_pkg::t_cmd               o_cmd,
    input  logic                         i_q_ready
);

    logic                   r_v;
    ppee_pkg::t_cmd         r_cmd;
    ppee_pkg::t_cmd         n_cmd;
    logic                   w_good;
    logic [ppee_pkg::PS_W-1:0] w_size;
    logic                   w_acc;

    assign o_ready = !r_v || i_q_ready;
    assign w_acc   = i_valid && o_ready;

    // config check and data area size
    assign w_good = (i_page_size[2:0] == 3'd0)
                 && (i_page_size > ppee_pkg::PS_W'(ppee_pkg::HEADER_BYTES))
                 && (32'(i_page_size) <= 32'(PAGE_BYTES));
    assign w_size = i_page_size - ppee_pkg::PS_W'(ppee_pkg::HEADER_BYTES);

    // classify
    always_comb begin
        n_cmd          = '0;
        n_cmd.addr     = i_addr;
        n_cmd.data     = i_data;
        n_cmd.last     = i_last;
        n_cmd.size     = w_size;
        n_cmd.in_range = {1'b0, i_addr} < w_size;
        case (ppee_pkg::t_mode'(i_mode))
            ppee_pkg::MODE_READ:  n_cmd.kind = ppee_pkg::K_READ;
            ppee_pkg::MODE_WRITE: n_cmd.kind = ppee_pkg::K_WRITE;
            ppee_pkg::MODE_ERASE: n_cmd.kind = ppee_pkg::K_ERASE;
            default:              n_cmd.kind = ppee_pkg::K_BAD;
        endcase
        if (!w_good) begin
            n_cmd.kind = ppee_pkg::K_BAD;
        end
    end

    // command register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else begin
            r_v <= w_acc || (r_v && !i_q_ready);
        end
        if (w_acc) begin
            r_cmd <= n_cmd;
        end
    end

    assign o_valid = r_v;
    assign o_cmd   = r_cmd;

endmodule

>>> rtl/core/ppee_queue.sv
// ----------------------------------------------------------------------------
// ppee_queue
// Two-entry command queue between front and back.
// ----------------------------------------------------------------------------
module ppee_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  ppee_pkg::t_cmd i_cmd,
    output logic           o_ready,
    input  logic           i_pop,
    output logic           o_valid,
    output ppee_pkg::t_cmd o_cmd
);

    ppee_pkg::t_cmd r_mem [2];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;
    logic           w_push;
    logic           w_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_mem[r_rp];
    assign w_push  = i_push && o_ready;
    assign w_pop   = i_pop && o_valid;

    // pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= !r_wp;
            if (w_pop)  r_rp <= !r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
        if (w_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

endmodule

>>> rtl/core/ppee_back.sv
// ----------------------------------------------------------------------------
// ppee_back
// Executes commands on the two page rams and drives the result register.
// ----------------------------------------------------------------------------
module ppee_back #(
    parameter int PAGE_BYTES = ppee_pkg::PAGE_BYTES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_q_valid,
    input  ppee_pkg::t_cmd              i_q_cmd,
    output logic                        o_q_pop,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [ppee_pkg::BYTE_W-1:0] o_read_data,
    output logic [1:0]                  o_status,
    output logic                        o_committed
);

    localparam int DEPTH  = PAGE_BYTES - ppee_pkg::HEADER_BYTES;
    localparam int AW     = $clog2(DEPTH);
    localparam int PW     = ppee_pkg::PS_W;
    // addressable part of the data area, rewritten in full on every copy
    localparam int CP_LEN = (DEPTH < 2**ppee_pkg::ADDR_W) ? DEPTH : 2**ppee_pkg::ADDR_W;

    ppee_pkg::t_bstate r_state, n_state;
    ppee_pkg::t_cmd    r_cmd, w_cur;
    logic              r_act, n_act;
    logic              r_open, n_open;
    logic              r_failed, n_failed;
    logic [PW-1:0]     r_fill [2];
    logic [PW-1:0]     n_fill [2];
    logic [PW-1:0]     r_cnt, n_cnt;
    logic              r_cp_v, n_cp_v;
    logic [PW-1:0]     r_cp_idx;
    logic              r_cp_keep, n_cp_keep;
    logic              r_keep, n_keep;
    logic              r_ov, n_ov;
    logic [7:0]        r_rd, n_rd;
    logic [1:0]        r_st, n_st;
    logic              r_cm, n_cm;

    logic              w_slot;
    logic              w_take;
    logic [PW-1:0]     w_rd_idx;
    logic [PW-1:0]     w_wr_idx;
    logic [7:0]        w_wdata;
    logic              w_we;
    logic [7:0]        w_rdata [2];
    logic [7:0]        w_rdata_act;
    logic              w_fail;

    assign w_slot      = !r_ov || i_ready;
    assign w_take      = (r_state == ppee_pkg::BS_IDLE) && i_q_valid && w_slot;
    assign o_q_pop     = w_take;
    assign w_cur       = (r_state == ppee_pkg::BS_IDLE) ? i_q_cmd : r_cmd;
    assign w_rdata_act = r_act ? w_rdata[1] : w_rdata[0];
    assign w_fail      = r_failed || !w_cur.in_range;

    // page rams: active page reads, inactive page writes
    for (genvar p = 0; p < 2; p++) begin : g_page
        logic          w_pact;
        logic [AW-1:0] w_a;
        assign w_pact = (r_act == 1'(p));
        assign w_a    = w_pact ? AW'(w_rd_idx) : AW'(w_wr_idx);
        ppee_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ram (
            .i_clk   (i_clk),
            .i_we    (w_we && !w_pact),
            .i_addr  (w_a),
            .i_wdata (w_wdata),
            .o_rdata (w_rdata[p])
        );
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ppee_pkg::BS_IDLE: begin
                if (w_take) begin
                    if (i_q_cmd.kind == ppee_pkg::K_READ && i_q_cmd.in_range) begin
                        n_state = ppee_pkg::BS_READ;
                    end else if (i_q_cmd.kind == ppee_pkg::K_WRITE && !r_open) begin
                        n_state = ppee_pkg::BS_COPY;
                    end
                end
            end
            ppee_pkg::BS_READ: n_state = ppee_pkg::BS_IDLE;
            ppee_pkg::BS_COPY: begin
                if (r_cnt >= PW'(CP_LEN) && !r_cp_v) begin
                    n_state = ppee_pkg::BS_EXEC;
                end
            end
            ppee_pkg::BS_EXEC: n_state = ppee_pkg::BS_IDLE;
            default:           n_state = ppee_pkg::BS_IDLE;
        endcase
    end

    // datapath and results
    always_comb begin
        n_act     = r_act;
        n_open    = r_open;
        n_failed  = r_failed;
        n_fill    = r_fill;
        n_cnt     = r_cnt;
        n_cp_v    = 1'b0;
        n_cp_keep = r_cp_keep;
        n_keep    = r_keep;
        n_ov      = r_ov && !i_ready;
        n_rd      = r_rd;
        n_st      = r_st;
        n_cm      = r_cm;
        w_rd_idx  = {1'b0, w_cur.addr};
        w_wr_idx  = {1'b0, w_cur.addr};
        w_wdata   = w_cur.data;
        w_we      = 1'b0;
        case (r_state)
            ppee_pkg::BS_IDLE: begin
                if (w_take) begin
                    case (i_q_cmd.kind)
                        ppee_pkg::K_READ: begin
                            n_keep = ({1'b0, i_q_cmd.addr} < r_fill[r_act]);
                            if (!i_q_cmd.in_range) begin
                                n_ov = 1'b1;
                                n_rd = 8'd0;
                                n_st = ppee_pkg::ST_RANGE;
                                n_cm = 1'b0;
                            end
                        end
                        ppee_pkg::K_ERASE: begin
                            n_act    = 1'b0;
                            n_open   = 1'b0;
                            n_failed = 1'b0;
                            n_fill[0] = '0;
                            n_fill[1] = '0;
                            n_ov = 1'b1;
                            n_rd = 8'd0;
                            n_st = ppee_pkg::ST_OK;
                            n_cm = 1'b0;
                        end
                        ppee_pkg::K_WRITE: begin
                            if (!r_open) begin
                                // start copy of active page into inactive one
                                n_cnt          = '0;
                                n_open         = 1'b1;
                                n_failed       = 1'b0;
                                n_fill[!r_act] = PW'(CP_LEN);
                            end
                        end
                        default: begin
                            n_ov = 1'b1;
                            n_rd = 8'd0;
                            n_st = ppee_pkg::ST_RANGE;
                            n_cm = 1'b0;
                        end
                    endcase
                end
            end
            ppee_pkg::BS_READ: begin
                n_ov = 1'b1;
                n_rd = r_keep ? w_rdata_act : 8'hFF;
                n_st = ppee_pkg::ST_OK;
                n_cm = 1'b0;
            end
            ppee_pkg::BS_COPY: begin
                // read at r_cnt, write the byte read in the previous cycle;
                // bytes past the data area are erased to 0xff
                w_rd_idx  = r_cnt;
                w_wr_idx  = r_cp_idx;
                w_wdata   = r_cp_keep ? w_rdata_act : 8'hFF;
                w_we      = r_cp_v;
                n_cp_v    = (r_cnt < PW'(CP_LEN));
                n_cp_keep = (r_cnt < r_cmd.size) && (r_cnt < r_fill[r_act]);
                if (r_cnt < PW'(CP_LEN)) begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            default: ;
        endcase

        // byte write of an open transaction
        if ((r_state == ppee_pkg::BS_EXEC)
            || (w_take && i_q_cmd.kind == ppee_pkg::K_WRITE && r_open)) begin
            w_we = w_cur.in_range;
            n_ov = 1'b1;
            n_rd = 8'd0;
            n_cm = 1'b0;
            n_st = w_cur.in_range ? ppee_pkg::ST_OK : ppee_pkg::ST_RANGE;
            n_open   = 1'b1;
            n_failed = w_fail;
            if (w_cur.last) begin
                n_open   = 1'b0;
                n_failed = 1'b0;
                if (w_fail) begin
                    n_st = ppee_pkg::ST_ABORT;
                end else begin
                    n_cm          = 1'b1;
                    n_act         = !r_act;
                    n_fill[r_act] = '0;
                end
            end
        end
    end

    // registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ppee_pkg::BS_IDLE;
            r_act    <= 1'b0;
            r_open   <= 1'b0;
            r_failed <= 1'b0;
            r_fill[0] <= '0;
            r_fill[1] <= '0;
            r_cp_v   <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_act    <= n_act;
            r_open   <= n_open;
            r_failed <= n_failed;
            r_fill   <= n_fill;
            r_cp_v   <= n_cp_v;
            r_ov     <= n_ov;
        end
        if (w_take) begin
            r_cmd <= i_q_cmd;
        end
        r_cnt     <= n_cnt;
        r_cp_idx  <= r_cnt;
        r_cp_keep <= n_cp_keep;
        r_keep    <= n_keep;
        r_rd      <= n_rd;
        r_st      <= n_st;
        r_cm      <= n_cm;
    end

    assign o_valid     = r_ov;
    assign o_read_data = r_rd;
    assign o_status    = r_st;
    assign o_committed = r_cm;

endmodule

>>> rtl/core/ping_pong_eeprom_emulator.sv
// ----------------------------------------------------------------------------
// ping_pong_eeprom_emulator
// Byte-addressed eeprom emulated on two page rams used in turn.
// ----------------------------------------------------------------------------
// channel   dir  handshake              payload
// s         in   i_s_tvalid/o_s_tready  i_s_tdata, i_s_tuser, i_s_tlast
// m         out  o_m_tvalid/i_m_tready  o_m_tdata
// cfg       in   i_cfg_valid/o_cfg_ready i_cfg_data (page_size)
//
// read: the back end passes through BS_READ for the registered ram read; erase,
// bad items and further write bytes: result registered at take; the first write
// byte of a transaction adds a page copy in BS_COPY, the whole data area one byte
// per cycle over the rams, with bytes past page_size-4 erased to 0xff.
// reset needs no clearing pass: per-page fill marks tell erased pages.
// front and back are split by a two-entry queue, so either side stalls alone.
// ----------------------------------------------------------------------------
module ping_pong_eeprom_emulator #(
    parameter int PAGE_BYTES = ppee_pkg::PAGE_BYTES_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [ppee_pkg::IN_TDATA_W-1:0]  i_s_tdata,  // address, data_byte
    input  logic [1:0]                       i_s_tuser,  // mode
    input  logic                             i_s_tlast,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    output logic [ppee_pkg::OUT_TDATA_W-1:0] o_m_tdata,  // read_data, status, committed
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [ppee_pkg::PS_W-1:0]        i_cfg_data
);

    logic [ppee_pkg::PS_W-1:0] r_page_size;
    logic                      w_f_valid;
    ppee_pkg::t_cmd            w_f_cmd;
    logic                      w_q_ready;
    logic                      w_q_valid;
    ppee_pkg::t_cmd            w_q_cmd;
    logic                      w_q_pop;
    logic [7:0]                w_rd;
    logic [1:0]                w_st;
    logic                      w_cm;

    // page size register
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page_size <= ppee_pkg::PS_W'(ppee_pkg::PAGE_BYTES_DEF);
        end else if (i_cfg_valid) begin
            r_page_size <= i_cfg_data;
        end
    end

    ppee_front #(.PAGE_BYTES(PAGE_BYTES)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_tvalid),
        .o_ready     (o_s_tready),
        .i_mode      (i_s_tuser),
        .i_addr      (i_s_tdata[10:0]),
        .i_data      (i_s_tdata[18:11]),
        .i_last      (i_s_tlast),
        .i_page_size (r_page_size),
        .o_valid     (w_f_valid),
        .o_cmd       (w_f_cmd),
        .i_q_ready   (w_q_ready)
    );

    ppee_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_f_valid),
        .i_cmd   (w_f_cmd),
        .o_ready (w_q_ready),
        .i_pop   (w_q_pop),
        .o_valid (w_q_valid),
        .o_cmd   (w_q_cmd)
    );

    ppee_back #(.PAGE_BYTES(PAGE_BYTES)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (w_q_valid),
        .i_q_cmd     (w_q_cmd),
        .o_q_pop     (w_q_pop),
        .o_valid     (o_m_tvalid),
        .i_ready     (i_m_tready),
        .o_read_data (w_rd),
        .o_status    (w_st),
        .o_committed (w_cm)
    );

    assign o_m_tdata = {5'd0, w_cm, w_st, w_rd};

endmodule
